[hw/rtl/stream_find_replace_core_assert.svh]
// Assertion macros for the find-and-replace core RTL.
`ifndef STREAM_FIND_REPLACE_CORE_ASSERT_SVH
`define STREAM_FIND_REPLACE_CORE_ASSERT_SVH

// Same-cycle implication, checked on i_clk outside reset.
`define SFR_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on i_clk outside reset.
`define SFR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/sfr_pkg.sv]
// Types, constants and helpers for the stream find-and-replace core.
package sfr_pkg;

    localparam int MAX_PATTERN_DEF    = 8;
    localparam int MAX_SUBSTITUTE_DEF = 8;
    localparam int LEN_W              = 4;
    localparam int CFG_W              = 64;
    localparam int CFG_IDX_W          = 3;
    localparam int WIN_IDX_W          = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_BYTES     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LENGTH    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SUBSTITUTE_BYTES  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SUBSTITUTE_LENGTH = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_REPLACE_ALL       = 3'd4;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } t_in;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_valid;
        logic       out_last;
    } t_out;

    typedef struct packed {
        logic                 wr_en;
        logic [WIN_IDX_W-1:0] wr_idx;
        logic                 shift;
        logic [WIN_IDX_W-1:0] rd_idx;
    } t_win_ctrl;

    function automatic logic [LEN_W-1:0] clamp_len(
        input logic [LEN_W-1:0] v,
        input logic [LEN_W-1:0] lo,
        input logic [LEN_W-1:0] hi
    );
        logic [LEN_W-1:0] r;
        if (v < lo) begin
            r = lo;
        end else if (v > hi) begin
            r = hi;
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

[hw/rtl/sfr_window.sv]
// Match window: byte shift line with one write port and one read port.
module sfr_window #(
    parameter int DEPTH = sfr_pkg::MAX_PATTERN_DEF
) (
    input  logic                  i_clk,
    input  sfr_pkg::t_win_ctrl    i_ctrl,
    input  logic [7:0]            i_wr_byte,
    output logic [7:0]            o_rd_byte
);

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [7:0] r_win [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_ctrl.wr_en) begin
            r_win[i_ctrl.wr_idx[IDX_W-1:0]] <= i_wr_byte;
        end else if (i_ctrl.shift) begin
            // drop the oldest byte
            for (int j = 0; j < DEPTH - 1; j++) begin
                r_win[j] <= r_win[j+1];
            end
        end
    end

    assign o_rd_byte = r_win[i_ctrl.rd_idx[IDX_W-1:0]];

endmodule

[hw/rtl/stream_find_replace_core.sv]
// Stream find-and-replace core: byte window, shared byte comparator, emit sequencer.
// A byte that neither fills the window nor ends the string is taken with no result;
// a last byte that leaves the window unfilled starts a flush of the buffered bytes.
// A byte that fills the window starts a compare over L bytes (L = pattern length, one byte
// per cycle through the shared comparator), then the result bytes are emitted.
// Input stalls outside the idle state, so no new byte is taken until those results are out.
// Reset (synchronous, active low): control and config registers reset, window empties.
module stream_find_replace_core #(
    parameter int MAX_PATTERN    = sfr_pkg::MAX_PATTERN_DEF,
    parameter int MAX_SUBSTITUTE = sfr_pkg::MAX_SUBSTITUTE_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  sfr_pkg::t_in                   i_in_data,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output sfr_pkg::t_out                  o_out_data,
    input  logic                           i_cfg_we,
    input  logic [sfr_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [sfr_pkg::CFG_W-1:0]      i_cfg_data
);

    `include "stream_find_replace_core_assert.svh"

    localparam int LEN_W     = sfr_pkg::LEN_W;
    localparam int WIN_DEPTH = (MAX_PATTERN < 8) ? MAX_PATTERN : 8;
    localparam int SUB_DEPTH = (MAX_SUBSTITUTE < 8) ? MAX_SUBSTITUTE : 8;
    localparam int CNT_DEPTH = (WIN_DEPTH > SUB_DEPTH) ? WIN_DEPTH : SUB_DEPTH;
    localparam int CNT_W     = (CNT_DEPTH > 1) ? $clog2(CNT_DEPTH) : 1;
    localparam int FILL_W    = $clog2(WIN_DEPTH + 1);

    localparam logic [LEN_W-1:0] PAT_HI = LEN_W'(WIN_DEPTH);
    localparam logic [LEN_W-1:0] SUB_HI = LEN_W'(SUB_DEPTH);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_CMP   = 3'd1;
    localparam logic [2:0] ST_SUB   = 3'd2;
    localparam logic [2:0] ST_EMIT  = 3'd3;
    localparam logic [2:0] ST_FLUSH = 3'd4;

    // configuration registers
    logic [63:0]      r_pat_bytes;
    logic [LEN_W-1:0] r_pat_len;
    logic [63:0]      r_sub_bytes;
    logic [LEN_W-1:0] r_sub_len;
    logic             r_rep_all;

    // sequencer state
    logic [2:0]        r_state, n_state;
    logic [CNT_W-1:0]  r_idx, n_idx;
    logic [FILL_W-1:0] r_fill, n_fill;
    logic [LEN_W-1:0]  r_act_len, n_act_len;
    logic              r_hit, n_hit;
    logic              r_done, n_done;
    logic              r_last, n_last;

    logic          r_out_valid;
    sfr_pkg::t_out r_out_data;

    sfr_pkg::t_win_ctrl win_ctrl;
    logic [7:0]         rd_byte;
    logic [7:0]         cmp_ref;
    logic               cmp_eq;
    logic               in_acc;
    logic               can_push;
    logic               push;
    sfr_pkg::t_out      push_data;
    logic [LEN_W-1:0]   pat_len_c;
    logic [LEN_W-1:0]   sub_len_c;
    logic [LEN_W-1:0]   len_now;
    logic [LEN_W-1:0]   idx_next;
    logic [LEN_W-1:0]   fill_len;

    sfr_window #(
        .DEPTH (WIN_DEPTH)
    ) u_window (
        .i_clk     (i_clk),
        .i_ctrl    (win_ctrl),
        .i_wr_byte (i_in_data.in_byte),
        .o_rd_byte (rd_byte)
    );

    assign o_in_stall  = (r_state != ST_IDLE);
    assign in_acc      = i_in_valid && !o_in_stall;
    assign can_push    = !r_out_valid || !i_out_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    assign pat_len_c = sfr_pkg::clamp_len(r_pat_len, LEN_W'(1), PAT_HI);
    assign sub_len_c = sfr_pkg::clamp_len(r_sub_len, LEN_W'(0), SUB_HI);
    assign len_now   = (r_fill == '0) ? pat_len_c : r_act_len;
    assign idx_next  = LEN_W'(r_idx) + LEN_W'(1);
    assign fill_len  = LEN_W'(r_fill);

    // shared byte comparator, stepped across the window
    assign cmp_ref = r_pat_bytes[8*r_idx +: 8];
    assign cmp_eq  = (rd_byte == cmp_ref);

    always_comb begin
        n_state   = r_state;
        n_idx     = r_idx;
        n_fill    = r_fill;
        n_act_len = r_act_len;
        n_hit     = r_hit;
        n_done    = r_done;
        n_last    = r_last;
        win_ctrl  = '0;
        push      = 1'b0;
        push_data = '0;
        unique case (r_state)
            ST_IDLE: begin
                win_ctrl.wr_idx = sfr_pkg::WIN_IDX_W'(r_fill);
                if (in_acc) begin
                    win_ctrl.wr_en = 1'b1;
                    n_last    = i_in_data.in_last;
                    n_act_len = len_now;
                    n_fill    = FILL_W'(r_fill + 1'b1);
                    n_hit     = r_rep_all || !r_done;
                    n_idx     = '0;
                    if (fill_len + LEN_W'(1) == len_now) begin
                        n_state = ST_CMP;
                    end else if (i_in_data.in_last) begin
                        n_state = ST_FLUSH;
                    end
                end
            end
            ST_CMP: begin
                win_ctrl.rd_idx = sfr_pkg::WIN_IDX_W'(r_idx);
                if (idx_next == r_act_len) begin
                    n_idx = '0;
                    if (r_hit && cmp_eq) begin
                        n_fill = '0;
                        n_done = 1'b1;
                        if (sub_len_c != '0) begin
                            n_state = ST_SUB;
                        end else if (r_last) begin
                            n_state = ST_FLUSH;
                        end else begin
                            n_state = ST_IDLE;
                        end
                    end else if (r_last) begin
                        // flushing the full window covers the oldest byte too
                        n_state = ST_FLUSH;
                    end else begin
                        n_state = ST_EMIT;
                    end
                end else begin
                    n_hit = r_hit && cmp_eq;
                    n_idx = CNT_W'(r_idx + 1'b1);
                end
            end
            ST_SUB: begin
                if (can_push) begin
                    push                = 1'b1;
                    push_data.out_byte  = r_sub_bytes[8*r_idx +: 8];
                    push_data.out_valid = 1'b1;
                    push_data.out_last  = r_last && (idx_next == sub_len_c);
                    if (idx_next == sub_len_c) begin
                        n_idx   = '0;
                        n_state = ST_IDLE;
                        if (r_last) begin
                            n_done = 1'b0;
                        end
                    end else begin
                        n_idx = CNT_W'(r_idx + 1'b1);
                    end
                end
            end
            ST_EMIT: begin
                if (can_push) begin
                    push                = 1'b1;
                    push_data.out_byte  = rd_byte;
                    push_data.out_valid = 1'b1;
                    win_ctrl.shift      = 1'b1;
                    n_fill              = FILL_W'(r_fill - 1'b1);
                    n_state             = ST_IDLE;
                end
            end
            ST_FLUSH: begin
                win_ctrl.rd_idx = sfr_pkg::WIN_IDX_W'(r_idx);
                if (can_push) begin
                    push = 1'b1;
                    if (r_fill == '0) begin
                        // nothing left: send the empty end marker
                        push_data.out_last = 1'b1;
                        n_done             = 1'b0;
                        n_state            = ST_IDLE;
                    end else begin
                        push_data.out_byte  = rd_byte;
                        push_data.out_valid = 1'b1;
                        push_data.out_last  = (idx_next == fill_len);
                        if (idx_next == fill_len) begin
                            n_idx   = '0;
                            n_fill  = '0;
                            n_done  = 1'b0;
                            n_state = ST_IDLE;
                        end else begin
                            n_idx = CNT_W'(r_idx + 1'b1);
                        end
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat_bytes <= '0;
            r_pat_len   <= LEN_W'(1);
            r_sub_bytes <= '0;
            r_sub_len   <= '0;
            r_rep_all   <= 1'b1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                sfr_pkg::CFG_PATTERN_BYTES:     r_pat_bytes <= i_cfg_data;
                sfr_pkg::CFG_PATTERN_LENGTH:    r_pat_len   <= i_cfg_data[LEN_W-1:0];
                sfr_pkg::CFG_SUBSTITUTE_BYTES:  r_sub_bytes <= i_cfg_data;
                sfr_pkg::CFG_SUBSTITUTE_LENGTH: r_sub_len   <= i_cfg_data[LEN_W-1:0];
                sfr_pkg::CFG_REPLACE_ALL:       r_rep_all   <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_idx     <= '0;
            r_fill    <= '0;
            r_act_len <= LEN_W'(1);
            r_hit     <= 1'b0;
            r_done    <= 1'b0;
            r_last    <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_idx     <= n_idx;
            r_fill    <= n_fill;
            r_act_len <= n_act_len;
            r_hit     <= n_hit;
            r_done    <= n_done;
            r_last    <= n_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (can_push) begin
            r_out_valid <= push;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_out_data <= push_data;
        end
    end

    `SFR_ASSERT_NOW(a_fill_below_len, (r_state == ST_IDLE) && (r_fill != '0), fill_len < r_act_len, "window fill reached active length while idle")
    `SFR_ASSERT_NOW(a_cmp_idx_range, r_state == ST_CMP, idx_next <= r_act_len, "compare index ran past pattern length")
    `SFR_ASSERT_NOW(a_marker_is_last, r_out_valid && !r_out_data.out_valid, r_out_data.out_last, "empty result without end mark")
    `SFR_ASSERT_NEXT(a_full_goes_cmp, in_acc && (fill_len + LEN_W'(1) == len_now), r_state == ST_CMP, "full window did not start a compare")

endmodule
